### src/assert_macros.svh
// Assertion macros for the top level of the set union/intersection unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check sampled at every rising clock edge outside reset
`define SSUI_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Same-cycle implication
`define SSUI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define SSUI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/ssui_pkg.sv
// Package: types and constants of the set union/intersection unit
package ssui_pkg;

   localparam int SET_DEPTH_DEF = 16;
   localparam int ELEM_W        = 32;

   localparam logic OP_UNION     = 1'b0;
   localparam logic OP_INTERSECT = 1'b1;

   localparam logic SEL_SET_A = 1'b0;
   localparam logic SEL_SET_B = 1'b1;

   typedef enum logic {
      ST_LOAD,
      ST_MERGE
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } row_cmd_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] head;
      logic                     empty;
      logic                     full;
   } row_stat_type;

endpackage

### src/ssui_if.sv
// Channel interfaces: load requests, result responses and the CSR write port
interface ssui_req_if;
   logic               valid;
   logic               ready;
   logic               set_select;
   logic signed [31:0] element;
   logic               load_done;

   modport source (output valid, set_select, element, load_done, input ready);
   modport sink   (input valid, set_select, element, load_done, output ready);
endinterface

interface ssui_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] member;
   logic               run_end;
   logic               empty_res;
   logic               overflow;

   modport source (output valid, member, run_end, empty_res, overflow, input ready);
   modport sink   (input valid, member, run_end, empty_res, overflow, output ready);
endinterface

interface ssui_csr_if;
   logic valid;
   logic ready;
   logic operation;

   modport source (output valid, operation, input ready);
   modport sink   (input valid, operation, output ready);
endinterface

### src/ssui_cell.sv
// One cell of a sorted chain: holds one element, inserts or shifts towards the head
module ssui_cell (
   input  logic                                clock,
   input  ssui_pkg::cell_cmd_type              cmd,
   input  logic                                valid,
   input  logic signed [ssui_pkg::ELEM_W-1:0]  new_value,
   input  logic signed [ssui_pkg::ELEM_W-1:0]  left_value,
   input  logic                                left_take,
   input  logic signed [ssui_pkg::ELEM_W-1:0]  right_value,
   output logic signed [ssui_pkg::ELEM_W-1:0]  value,
   output logic                                take
);
   import ssui_pkg::*;

   logic signed [ELEM_W-1:0] value_ff;
   logic signed [ELEM_W-1:0] value_in;

   // insertion point is at or before this cell
   assign take = !valid || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (take) begin
            value_in = left_take ? left_value : new_value;
         end
      end else if (cmd.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### src/ssui_row.sv
// Row of cells holding one set in ascending order, with its fill count
module ssui_row #(
   parameter int DEPTH = ssui_pkg::SET_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssui_pkg::row_cmd_type              cmd,
   input  logic signed [ssui_pkg::ELEM_W-1:0] element,
   output ssui_pkg::row_stat_type             stat
);
   import ssui_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     full;
   logic                     empty;
   cell_cmd_type             cell_cmd;
   logic signed [ELEM_W-1:0] val_w  [DEPTH];
   logic                     take_w [DEPTH];

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign cell_cmd.insert = cmd.insert && !full && !cmd.clear;
   assign cell_cmd.shift  = cmd.shift && !empty && !cmd.clear;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ELEM_W-1:0] left_v;
      logic                     left_t;
      logic signed [ELEM_W-1:0] right_v;

      if (i == 0) begin : g_head
         assign left_v = element;
         assign left_t = 1'b0;
      end else begin : g_body
         assign left_v = val_w[i-1];
         assign left_t = take_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_v = val_w[i];
      end else begin : g_mid
         assign right_v = val_w[i+1];
      end

      ssui_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .valid       (CNT_W'(i) < count_ff),
         .new_value   (element),
         .left_value  (left_v),
         .left_take   (left_t),
         .right_value (right_v),
         .value       (val_w[i]),
         .take        (take_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cell_cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cell_cmd.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.head  = val_w[0];
   assign stat.empty = empty;
   assign stat.full  = full;

endmodule

### src/set_sort_union_intersection_unit.sv
// Top level: sorted two-set loader with union/intersection merge output
//
// req_chan: load transactions. Each carries an element and the set it joins
//   (set_select 0 = A, 1 = B). Each set is a chain of SET_DEPTH cells kept in
//   ascending order; one element is inserted per cycle. Elements arriving at a
//   full set are dropped and the run is flagged with overflow.
// load_done marks the last element; the unit then stops taking loads and
//   merges both chains, shifting the head cells out one step per cycle.
// rsp_chan: result transactions in ascending order, the last with run_end.
//   csr_chan.operation 0 gives the union, 1 the intersection. An empty result
//   is one transaction with empty_res set and member zero.
// Output path: with a free receiver an empty result is loaded into the output
//   register in the first merge step, while the first union result passes
//   through the pending register first; an intersection result waits for a
//   matching pair of heads. Then one result per cycle (union) while it is taken.
// A stalled receiver holds the output register and halts the merge. Reset empties
//   both sets and clears the operation to union.
`include "assert_macros.svh"

module set_sort_union_intersection_unit #(
   parameter int SET_DEPTH = ssui_pkg::SET_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssui_req_if.sink   req_chan,
   ssui_rsp_if.source rsp_chan,
   ssui_csr_if.sink   csr_chan
);
   import ssui_pkg::*;

   state_type                state_ff, state_in;
   logic                     operation_ff;
   logic                     dropped_ff, dropped_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic signed [ELEM_W-1:0] pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] rsp_member_ff, rsp_member_in;
   logic                     rsp_end_ff, rsp_end_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   row_cmd_type  cmd_a, cmd_b;
   row_stat_type stat_a, stat_b;

   logic req_fire, out_free, merge_done, out_load;
   logic a_lt, b_lt, eq;

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign merge_done = (operation_ff == OP_INTERSECT) ? (stat_a.empty || stat_b.empty)
                                                      : (stat_a.empty && stat_b.empty);

   assign a_lt = !stat_a.empty && (stat_b.empty || (stat_a.head < stat_b.head));
   assign b_lt = !stat_b.empty && (stat_a.empty || (stat_b.head < stat_a.head));
   assign eq   = !stat_a.empty && !stat_b.empty && (stat_a.head == stat_b.head);

   ssui_row #(.DEPTH(SET_DEPTH)) u_row_a (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd_a),
      .element (req_chan.element),
      .stat    (stat_a)
   );

   ssui_row #(.DEPTH(SET_DEPTH)) u_row_b (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd_b),
      .element (req_chan.element),
      .stat    (stat_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_chan.load_done) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (out_free && merge_done) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath control
   always_comb begin
      cmd_a         = '0;
      cmd_b         = '0;
      dropped_in    = dropped_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_load      = 1'b0;
      rsp_member_in = pend_ff;
      rsp_end_in    = 1'b0;
      rsp_empty_in  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (req_chan.set_select == SEL_SET_B) begin
                  cmd_b.insert = 1'b1;
                  if (stat_b.full) begin
                     dropped_in = 1'b1;
                  end
               end else begin
                  cmd_a.insert = 1'b1;
                  if (stat_a.full) begin
                     dropped_in = 1'b1;
                  end
               end
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               if (merge_done) begin
                  out_load      = 1'b1;
                  rsp_end_in    = 1'b1;
                  rsp_empty_in  = !pend_valid_ff;
                  rsp_member_in = pend_valid_ff ? pend_ff : '0;
                  pend_valid_in = 1'b0;
                  dropped_in    = 1'b0;
                  cmd_a.clear   = 1'b1;
                  cmd_b.clear   = 1'b1;
               end else begin
                  cmd_a.shift = a_lt || eq;
                  cmd_b.shift = b_lt || eq;
                  if (eq || (operation_ff == OP_UNION)) begin
                     out_load      = pend_valid_ff;
                     pend_in       = a_lt ? stat_a.head : stat_b.head;
                     pend_valid_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_ovf_in   = dropped_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         operation_ff  <= OP_UNION;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dropped_ff    <= dropped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            operation_ff <= csr_chan.operation;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (out_load) begin
         rsp_member_ff <= rsp_member_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_ovf_ff    <= rsp_ovf_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.member    = rsp_member_ff;
   assign rsp_chan.run_end   = rsp_end_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;

   `SSUI_ASSERT_IMPLY(a_no_pend_in_load, clock, reset, state_ff == ST_LOAD, !pend_valid_ff)
   `SSUI_ASSERT_IMPLY(a_load_when_free, clock, reset, out_load, out_free)
   `SSUI_ASSERT_NEXT(a_done_starts_merge, clock, reset, req_fire && req_chan.load_done, state_ff == ST_MERGE)
   `SSUI_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_end_ff && (rsp_member_ff == '0))

endmodule
